FILE: design/four_lane_streaming_hash64_core_defines.svh
// assertion macros for the four-lane hash core checker
// used by the checker file only
`ifndef FOUR_LANE_STREAMING_HASH64_CORE_DEFINES_SVH
`define FOUR_LANE_STREAMING_HASH64_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FLH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define FLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/flh_pkg.sv
// shared constants, types and helpers for the four-lane hash core
// no dependencies
`timescale 1ns / 1ps
package flh_pkg;
    localparam logic [63:0] P1    = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2    = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3    = 64'h165667B19E3779F9;
    localparam logic [63:0] P4    = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5    = 64'h27D4EB2F165667C5;
    localparam logic [63:0] MIX_A = 64'hff51afd7ed598ccd;
    localparam logic [63:0] MIX_B = 64'hc4ceb9fe1a85ec53;

    localparam logic [0:0] CFG_SEED = 1'b0;
    localparam logic [0:0] CFG_OUTW = 1'b1;

    // request to the shared multiplier: a * b, low 64 bits
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] d;
        begin
            d = {x, x} << r;
            rotl = d[127:64];
        end
    endfunction
endpackage

FILE: design/four_lane_streaming_hash64_core.sv
// channel  | handshake         | payload
// in       | in_valid/in_stall | data_word, byte_count, last_item
// out      | out_valid/out_stall | hash_word, last_word
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
// Bytes of an item are appended one per cycle, pausing while a full 32-byte
// block runs four lane rounds on the shared multiplier (three products each).
// A last item then runs the finishing steps, and each extra hash word runs
// a further mix on the multiplier.
// Reset loads lanes from a zero seed; a pending cfg write stalls the input;
// out_stall holds the output register and the sequencer waiting to emit.
// four-lane hash core top level: sequencer around one shared multiplier
// depends on flh_pkg and flh_mul
`timescale 1ns / 1ps
module four_lane_streaming_hash64_core
    import flh_pkg::*;
#(
    parameter int MAX_OUT_WORDS = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_word,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int OW = $clog2(MAX_OUT_WORDS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_BYTE, S_RND_A, S_RND_B, S_RND_C, S_FIN_SEL,
        S_MRG_A, S_MRG_B, S_MRG_C, S_MRG_D, S_LEN,
        S_T8_A, S_T8_B, S_T8_C, S_T8_D, S_T4_A, S_T4_B,
        S_T1_A, S_T1_B, S_AV_A, S_AV_B, S_AV_C,
        S_EMIT, S_MX_A, S_MX_B, S_MX_C, S_WAIT
    } state_t;

    state_t      state_reg;
    logic [63:0] seed_reg;
    logic [3:0]  outw_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [4];
    logic [63:0] len_reg;
    logic [4:0]  fill_reg;
    logic [63:0] word_reg;
    logic [3:0]  cnt_reg;
    logic        lastf_reg;
    logic [3:0]  bi_reg;
    logic [1:0]  ln_reg;
    logic [63:0] h_reg, t_reg;
    logic [4:0]  p_reg;
    logic [OW-1:0] n_reg, wi_reg;
    logic        ov_reg;
    logic [63:0] ow_reg;
    logic        ol_reg;
    mul_req_t    mreq;
    mul_rsp_t    mrsp;
    logic [OW-1:0] n_eff;
    logic [63:0] x_w;

    flh_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign hash_word = ow_reg;
    assign last_word = ol_reg;
    assign x_w = lane_reg[ln_reg] ^ buf_reg[ln_reg];

    // clamp of the output word count
    always_comb
    begin
        if (outw_reg == 4'd0)
            n_eff = OW'(1);
        else if (32'(outw_reg) > MAX_OUT_WORDS)
            n_eff = OW'(MAX_OUT_WORDS);
        else
            n_eff = OW'(outw_reg);
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seed_reg  <= '0;
            outw_reg  <= 4'd1;
            lane_reg[0] <= P1 + P2;
            lane_reg[1] <= P2;
            lane_reg[2] <= '0;
            lane_reg[3] <= -P1;
            len_reg   <= '0;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
            mreq      <= '0;
        end
        else
        begin
            mreq.start <= 1'b0;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_SEED)
                        begin
                            seed_reg    <= cfg_data;
                            lane_reg[0] <= cfg_data + P1 + P2;
                            lane_reg[1] <= cfg_data + P2;
                            lane_reg[2] <= cfg_data;
                            lane_reg[3] <= cfg_data - P1;
                            len_reg     <= '0;
                            fill_reg    <= '0;
                        end
                        else
                            outw_reg <= cfg_data[3:0];
                    end
                    else if (in_valid)
                    begin
                        word_reg  <= data_word;
                        cnt_reg   <= (byte_count > 4'd8) ? 4'd8 : byte_count;
                        lastf_reg <= last_item;
                        bi_reg    <= '0;
                        state_reg <= S_BYTE;
                    end
                end
                S_BYTE:
                begin
                    if (bi_reg == cnt_reg)
                        state_reg <= lastf_reg ? S_FIN_SEL : S_IDLE;
                    else
                    begin
                        buf_reg[fill_reg[4:3]][fill_reg[2:0]*8 +: 8] <= word_reg[7:0];
                        word_reg <= word_reg >> 8;
                        bi_reg   <= bi_reg + 4'd1;
                        len_reg  <= len_reg + 64'd1;
                        fill_reg <= fill_reg + 5'd1;
                        if (fill_reg == 5'd31)
                        begin
                            ln_reg    <= 2'd0;
                            state_reg <= S_RND_A;
                        end
                    end
                end
                // lane round: chaos product, then w*P2, then *P1
                S_RND_A:
                begin
                    mreq <= '{1'b1, {32'd0, x_w[63:32]}, {32'd0, ~x_w[63:32]}};
                    state_reg <= S_RND_B;
                end
                S_RND_B:
                begin
                    if (mrsp.done)
                    begin
                        t_reg <= mrsp.p;
                        mreq <= '{1'b1, buf_reg[ln_reg], P2};
                        state_reg <= S_RND_C;
                    end
                end
                S_RND_C:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, rotl(t_reg + mrsp.p, 6'd31), P1};
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        lane_reg[ln_reg] <= mrsp.p;
                        ln_reg <= ln_reg + 2'd1;
                        state_reg <= (ln_reg == 2'd3) ? S_BYTE : S_RND_A;
                    end
                end
                S_FIN_SEL:
                begin
                    p_reg <= '0;
                    ln_reg <= 2'd0;
                    if (len_reg >= 64'd32)
                    begin
                        h_reg <= rotl(lane_reg[0], 6'd1) + rotl(lane_reg[1], 6'd7)
                               + rotl(lane_reg[2], 6'd12) + rotl(lane_reg[3], 6'd18);
                        state_reg <= S_MRG_A;
                    end
                    else
                    begin
                        h_reg <= lane_reg[2] + P5;
                        state_reg <= S_LEN;
                    end
                end
                S_MRG_A:
                begin
                    mreq <= '{1'b1, lane_reg[ln_reg], P2};
                    state_reg <= S_MRG_B;
                end
                S_MRG_B:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, rotl(mrsp.p, 6'd31), P1};
                        state_reg <= S_MRG_C;
                    end
                end
                S_MRG_C:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, h_reg ^ mrsp.p, P1};
                        state_reg <= S_MRG_D;
                    end
                end
                S_MRG_D:
                begin
                    if (mrsp.done)
                    begin
                        h_reg <= mrsp.p + P4;
                        ln_reg <= ln_reg + 2'd1;
                        state_reg <= (ln_reg == 2'd3) ? S_LEN : S_MRG_A;
                    end
                end
                S_LEN:
                begin
                    h_reg <= h_reg + len_reg;
                    state_reg <= S_T8_A;
                end
                // tail: whole words, one half word, single bytes
                S_T8_A:
                begin
                    if (6'(p_reg) + 6'd8 <= 6'(fill_reg))
                    begin
                        mreq <= '{1'b1, buf_reg[p_reg[4:3]], P2};
                        state_reg <= S_T8_B;
                    end
                    else if (6'(p_reg) + 6'd4 <= 6'(fill_reg))
                    begin
                        mreq <= '{1'b1, {32'd0, buf_reg[p_reg[4:3]][31:0]}, P1};
                        state_reg <= S_T4_A;
                    end
                    else
                        state_reg <= S_T1_A;
                end
                S_T8_B:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, rotl(mrsp.p, 6'd31), P1};
                        state_reg <= S_T8_C;
                    end
                end
                S_T8_C:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, rotl(h_reg ^ mrsp.p, 6'd27), P1};
                        state_reg <= S_T8_D;
                    end
                end
                S_T8_D:
                begin
                    if (mrsp.done)
                    begin
                        h_reg <= mrsp.p + P4;
                        p_reg <= p_reg + 5'd8;
                        state_reg <= S_T8_A;
                    end
                end
                S_T4_A:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, rotl(h_reg ^ mrsp.p, 6'd23), P2};
                        state_reg <= S_T4_B;
                    end
                end
                S_T4_B:
                begin
                    if (mrsp.done)
                    begin
                        h_reg <= mrsp.p + P3;
                        p_reg <= p_reg + 5'd4;
                        state_reg <= S_T1_A;
                    end
                end
                S_T1_A:
                begin
                    if (p_reg >= fill_reg)
                    begin
                        mreq <= '{1'b1, h_reg ^ (h_reg >> 33), P2};
                        state_reg <= S_AV_A;
                    end
                    else
                    begin
                        mreq <= '{1'b1, rotl(h_reg ^ ({56'd0,
                                buf_reg[p_reg[4:3]][p_reg[2:0]*8 +: 8]} * P5), 6'd11), P1};
                        state_reg <= S_T1_B;
                    end
                end
                S_T1_B:
                begin
                    if (mrsp.done)
                    begin
                        h_reg <= mrsp.p;
                        p_reg <= p_reg + 5'd1;
                        state_reg <= S_T1_A;
                    end
                end
                S_AV_A:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, mrsp.p ^ (mrsp.p >> 29), P3};
                        state_reg <= S_AV_B;
                    end
                end
                S_AV_B:
                begin
                    if (mrsp.done)
                    begin
                        h_reg  <= mrsp.p ^ (mrsp.p >> 32);
                        n_reg  <= n_eff;
                        wi_reg <= OW'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        ow_reg <= h_reg;
                        ol_reg <= (wi_reg == n_reg);
                        if (wi_reg == n_reg)
                        begin
                            lane_reg[0] <= seed_reg + P1 + P2;
                            lane_reg[1] <= seed_reg + P2;
                            lane_reg[2] <= seed_reg;
                            lane_reg[3] <= seed_reg - P1;
                            len_reg  <= '0;
                            fill_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            t_reg <= h_reg + P5;
                            state_reg <= S_MX_A;
                        end
                    end
                end
                // murmur mix of previous word plus P5
                S_MX_A:
                begin
                    mreq <= '{1'b1, t_reg ^ (t_reg >> 33), MIX_A};
                    state_reg <= S_MX_B;
                end
                S_MX_B:
                begin
                    if (mrsp.done)
                    begin
                        mreq <= '{1'b1, mrsp.p ^ (mrsp.p >> 33), MIX_B};
                        state_reg <= S_MX_C;
                    end
                end
                S_MX_C:
                begin
                    if (mrsp.done)
                    begin
                        h_reg  <= mrsp.p ^ (mrsp.p >> 33);
                        wi_reg <= wi_reg + OW'(1);
                        state_reg <= S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/flh_mul.sv
// shared 64x64 low-half multiplier, three 32x32 partial products over cycles
// depends on flh_pkg
`timescale 1ns / 1ps
module flh_mul
    import flh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);
    logic [63:0] a_reg, b_reg, acc_reg;
    logic [2:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] op_a, op_b;
    logic [63:0] pp_reg;

    // operand pick per step: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    begin op_a = a_reg[31:0];  op_b = b_reg[31:0];  end
            2'd1:    begin op_a = a_reg[31:0];  op_b = b_reg[63:32]; end
            default: begin op_a = a_reg[63:32]; op_b = b_reg[31:0];  end
        endcase
    end

    // sequencer: step 0..2 multiply, 1..3 accumulate registered product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= {32'd0, op_a} * {32'd0, op_b};
            unique case (step_reg)
                3'd1:    acc_reg <= pp_reg;
                3'd2:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                3'd3:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;
endmodule

FILE: design/flh_checker.sv
// port-level checker for the four-lane hash core, with its bind
// depends on four_lane_streaming_hash64_core_defines.svh
`timescale 1ns / 1ps
`include "four_lane_streaming_hash64_core_defines.svh"
module flh_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic last_word,
    input logic [63:0] hash_word,
    input logic cfg_valid,
    input logic cfg_ready
);
    // idle with no config pending leaves the input unstalled
    `FLH_ASSERT_IMP(a_cfg_idle, cfg_ready && !cfg_valid, !in_stall, "cfg ready while busy")
    // accepted item makes the block busy
    `FLH_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "not busy")
    // stalled output holds
    `FLH_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(hash_word), "out dropped")
    // an accepted final word, with the input idle, is followed by no further valid word
    `FLH_ASSERT_NEXT(a_end, out_valid && last_word && !out_stall && !in_stall, !out_valid, "extra word")
endmodule

bind four_lane_streaming_hash64_core flh_checker u_flh_checker (.*);
